/* hdl/ohi_pkg.sv */
// Shared types and constants for the open-addressing hash insert block.
`default_nettype none
package ohi_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int KEY_W           = 32;
	localparam int SIZE_W          = 11;
	localparam int SLOT_W          = 10;
	localparam int PROBE_W         = 11;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 11;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_SIZE = 1'b0,
		CFG_PROBE_MODE = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		RC_INSERTED  = 2'd0,
		RC_DUPLICATE = 2'd1,
		RC_FULL      = 2'd2,
		RC_CLEARED   = 2'd3
	} rsp_code_t;

	typedef struct packed {
		opcode_t                  opcode;
		logic signed [KEY_W-1:0]  key_value;
	} req_t;

	typedef struct packed {
		rsp_code_t                status;
		logic [SLOT_W-1:0]        slot_index;
		logic [PROBE_W-1:0]       probe_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_WIPE,
		S_IDLE,
		S_MOD,
		S_READ,
		S_CHECK,
		S_CLEAR,
		S_DONE
	} fsm_state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_INSERT,
		RES_DUP,
		RES_FULL,
		RES_CLEAR
	} res_sel_t;

	typedef struct packed {
		logic     accept;
		logic     clr_step;
		logic     probe_init;
		logic     probe_next;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_clear;
		logic mod_done;
		logic clr_last;
		logic slot_empty;
		logic slot_match;
		logic probe_last;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hdl/ohi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ohi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/ohi_mod_unit.sv */
// Bit-serial remainder unit: 32-bit dividend modulo an 11-bit divisor.
`default_nettype none
module ohi_mod_unit import ohi_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [KEY_W-1:0]  dividend,
	input  wire logic [SIZE_W-1:0] divisor,
	output      logic              done,
	output      logic [SIZE_W-1:0] remainder
);

	localparam int CNT_W = $clog2(KEY_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [KEY_W-1:0]  dvd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic [SIZE_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[KEY_W-1]};
		diff    = trial - {1'b0, divisor};
		rem_nxt = (trial >= {1'b0, divisor}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

/* hdl/ohi_datapath.sv */
// Datapath: config registers, home slot, probe sequence, slot memory and result register.
`default_nettype none
module ohi_datapath import ohi_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire req_t                  req_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire ctrl_cmd_t             cmd,
	output      dp_stat_t              stat,
	output      logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	output      rsp_t                  rsp_data
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam logic [SIZE_W-1:0] DEPTH_CAP =
		(TABLE_DEPTH > int'(SIZE_MAX)) ? SIZE_MAX : SIZE_W'(TABLE_DEPTH);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(TABLE_DEPTH - 1);

	logic [SIZE_W-1:0] table_size_q;
	logic              probe_mode_q;
	logic [SIZE_W-1:0] eff_size;
	logic [KEY_W-1:0]  key_raw;
	logic [KEY_W-1:0]  key_mag;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic              mod_done;
	logic [SIZE_W-1:0] home;
	logic [SIZE_W-1:0] pos_q;
	logic [SIZE_W-1:0] dlt_q;
	logic [SIZE_W-1:0] idx_q;
	logic [SIZE_W:0]   pos_sum;
	logic [SIZE_W:0]   dlt_sum;
	logic [SIZE_W-1:0] pos_nxt;
	logic [SIZE_W-1:0] dlt_nxt;
	logic [PROBE_W-1:0] probes;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [KEY_W-1:0]  ram_wdata;
	logic [KEY_W-1:0]  ram_rdata;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_RESET;
			probe_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TABLE_SIZE: table_size_q <= cfg_data[SIZE_W-1:0];
				CFG_PROBE_MODE: probe_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_size = (table_size_q == '0) ? SIZE_W'(1) : table_size_q;
		if (eff_size > DEPTH_CAP) begin
			eff_size = DEPTH_CAP;
		end
		key_raw = req_data.key_value;
		key_mag = key_raw[KEY_W-1] ? ('0 - key_raw) : key_raw;
	end

	ohi_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.accept),
		.dividend  (key_mag),
		.divisor   (size_q),
		.done      (mod_done),
		.remainder (home)
	);

	// probe sequence: step is 1 (linear) or the running odd number mod size (quadratic)
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, dlt_q};
		pos_nxt = (pos_sum >= {1'b0, size_q}) ? SIZE_W'(pos_sum - {1'b0, size_q})
			: pos_sum[SIZE_W-1:0];
		dlt_sum = {1'b0, dlt_q} + (SIZE_W+1)'(2);
		dlt_nxt = (dlt_sum >= {1'b0, size_q}) ? SIZE_W'(dlt_sum - {1'b0, size_q})
			: dlt_sum[SIZE_W-1:0];
		probes  = PROBE_W'(idx_q) + PROBE_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q  <= key_raw;
			size_q <= eff_size;
		end
		if (cmd.probe_init) begin
			pos_q <= home;
			dlt_q <= (size_q == SIZE_W'(1)) ? '0 : SIZE_W'(1);
			idx_q <= '0;
		end else if (cmd.probe_next) begin
			pos_q <= pos_nxt;
			dlt_q <= probe_mode_q ? dlt_nxt : dlt_q;
			idx_q <= idx_q + SIZE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= (clr_cnt_q == CLR_LAST) ? '0 : clr_cnt_q + ADDR_W'(1);
		end
	end

	always_comb begin
		ram_we    = cmd.clr_step || (cmd.res_sel == RES_INSERT);
		ram_waddr = cmd.clr_step ? clr_cnt_q : ADDR_W'(pos_q);
		ram_wdata = cmd.clr_step ? '0 : key_q;
	end

	ohi_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ADDR_W'(pos_q)),
		.rdata (ram_rdata)
	);

	// result staging and output register
	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_INSERT: res_q <= '{RC_INSERTED, pos_q[SLOT_W-1:0], probes};
			RES_DUP:    res_q <= '{RC_DUPLICATE, pos_q[SLOT_W-1:0], probes};
			RES_FULL:   res_q <= '{RC_FULL, '0, probes};
			RES_CLEAR:  res_q <= '{RC_CLEARED, '0, '0};
			default: ;
		endcase
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.req_clear  = (req_data.opcode == OP_CLEAR);
		stat.mod_done   = mod_done;
		stat.clr_last   = (clr_cnt_q == CLR_LAST);
		stat.slot_empty = (ram_rdata == '0);
		stat.slot_match = (ram_rdata == key_q);
		stat.probe_last = (idx_q == size_q - SIZE_W'(1));
		stat.out_free   = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
`default_nettype wire

/* hdl/ohi_ctrl.sv */
// Controller state machine: wipe, accept, remainder wait, probe loop, clear sweep, result hand-off.
`default_nettype none
module ohi_ctrl import ohi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output      logic     req_ready,
	input  wire dp_stat_t stat,
	output      ctrl_cmd_t cmd
);

	fsm_state_t state_q;
	fsm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_WIPE: begin
				if (stat.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_nxt = stat.req_clear ? S_CLEAR : S_MOD;
			end
			S_MOD: begin
				if (stat.mod_done) state_nxt = S_READ;
			end
			S_READ: state_nxt = S_CHECK;
			S_CHECK: begin
				if (stat.slot_empty || stat.slot_match || stat.probe_last) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_READ;
				end
			end
			S_CLEAR: begin
				if (stat.clr_last) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_WIPE;
		endcase
	end

	always_comb begin
		cmd       = '{accept: 1'b0, clr_step: 1'b0, probe_init: 1'b0, probe_next: 1'b0,
			res_sel: RES_NONE, out_load: 1'b0};
		req_ready = 1'b0;
		case (state_q)
			S_WIPE: cmd.clr_step = 1'b1;
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid && !stat.req_clear;
			end
			S_MOD: cmd.probe_init = stat.mod_done;
			S_READ: ;
			S_CHECK: begin
				if (stat.slot_empty) begin
					cmd.res_sel = RES_INSERT;
				end else if (stat.slot_match) begin
					cmd.res_sel = RES_DUP;
				end else if (stat.probe_last) begin
					cmd.res_sel = RES_FULL;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) cmd.res_sel = RES_CLEAR;
			end
			S_DONE: cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/open_addressing_hash_insert.sv */
// Top level of the open-addressing hash insert engine.
//
// Request channel (req_valid/req_ready/req_data) carries one operation a beat:
// insert key_value, or clear the whole table. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns exactly one beat per request with
// status, slot_index and probe_count. One request is in flight at a time.
// An insert computes the home slot in the bit-serial remainder unit, probes
// slots through the registered read of the slot memory, and then loads the
// output register. A clear sweeps the memory one slot per cycle.
// After reset the same sweep runs with req_ready low; configuration writes
// are taken throughout. table_size and probe_mode are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no request is
// outstanding, as the block itself does not enforce it.
// The response sits in an output register: a stalled receiver holds it
// there while the next request is accepted and worked on; that request's
// result waits until the register frees.
`default_nettype none
module open_addressing_hash_insert import ohi_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output      logic                  req_ready,
	input  wire req_t                  req_data,
	output      logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	output      rsp_t                  rsp_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ohi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ohi_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule
`default_nettype wire

/* hdl/ohi_checker.sv */
// Port-level checker for the hash insert engine, bound to the top level.
`default_nettype none
module ohi_checker import ohi_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response beat changed");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == RC_CLEARED |->
			rsp_data.slot_index == '0 && rsp_data.probe_count == '0)
		else $error("clear response with nonzero slot or probe count");

	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == RC_FULL |->
			rsp_data.slot_index == '0 && rsp_data.probe_count != '0)
		else $error("full response with bad fields");

	a_hit_probed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == RC_INSERTED || rsp_data.status == RC_DUPLICATE)
			|-> rsp_data.probe_count != '0)
		else $error("insert or duplicate with zero probes");

endmodule

bind open_addressing_hash_insert ohi_checker u_ohi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);
`default_nettype wire
